>>> sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared widths, region limits, wedge constants and wall breakpoint tables.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int FRAC_BITS_DEF = 4;
  localparam int COORD_W       = 19;
  localparam int CMP_W         = 24;
  localparam int WALL_W        = 28;
  localparam int PROD_W        = 2 * WALL_W;
  localparam int WEDGE_W       = 40;
  localparam int WIDE_W        = 64;

  // region limits, whole millimetres
  localparam int Z_MAX     = 7811;
  localparam int X_LIM_A   = -2049;
  localparam int X_LIM_B   = -5890;
  localparam int X_LIM_C   = -9125;
  localparam int Z_MIN_MID = 3769;
  localparam int Z_LO_FAR  = 3775;
  localparam int Z_HI_FAR  = 6800;
  localparam int C1_Z      = 4535;
  localparam int C1_X      = -3243;
  localparam int C1_AX     = 2345;
  localparam int C1_BZ     = 4520;
  localparam int C1_R      = 2970;
  localparam int C2_Z      = 4469;
  localparam int C2_X      = -2752;
  localparam int C2_AX     = 2135;
  localparam int C2_BZ     = 4295;
  localparam int C2_R      = 1585;
  localparam int W_Z       = 4469;
  localparam int W_X       = -3100;
  localparam int W_Z0      = 450;
  localparam int Y_LIM     = 1000;

  // wedge: cos, sin, gap/tilt (all /2^16), tan(tilt/2) (/2^24)
  localparam int WEDGE_COS   = 37590;
  localparam int WEDGE_SIN   = 53684;
  localparam int WEDGE_D     = 21487475;
  localparam int WEDGE_TAN   = 511858;
  localparam int WEDGE_SHIFT = 40;

  localparam int WALL_TOP = 0;
  localparam int WALL_BOT = 1;
  localparam int WALL_LFT = 2;
  localparam int WALL_RGT = 3;

  // breakpoints in 0.1 mm, z ascending
  localparam int TOP_Z [14] = '{42891, 46103, 47552, 48908, 49509, 50492, 51600,
                                52583, 53422, 54445, 55084, 55377, 55708, 55873};
  localparam int TOP_X [14] = '{-8856, -8856, -9357, -9798, -10159, -10922, -11744,
                                -12852, -13837, -15444, -16613, -17672, -19144, -20491};
  localparam int BOT_Z [24] = '{29682, 43885, 43893, 46714, 49894, 50966, 52939,
                                55185, 57232, 59162, 62228, 64193, 66380, 67294,
                                69317, 70934, 72221, 73655, 75031, 76057, 77275,
                                77636, 78100, 78107};
  localparam int BOT_X [24] = '{9288, 9293, 9619, 9619, 9310, 9154, 8773, 7961,
                                7191, 6390, 4844, 3408, 1858, 1094, -961, -2764,
                                -4578, -6801, -9419, -11854, -15571, -17175,
                                -20993, -25942};
  localparam int LFT_Z [9]  = '{37690, 44440, 54660, 54686, 55178, 55427, 55542,
                                55708, 55853};
  localparam int LFT_X [9]  = '{-58900, -39500, -33300, -26723, -25201, -24886,
                                -24115, -23473, -21775};
  localparam int RGT_Z [6]  = '{68090, 75020, 76641, 77391, 77868, 78107};
  localparam int RGT_X [6]  = '{-58960, -39600, -33327, -30874, -28490, -25942};

  typedef struct packed {
    logic z_bad;
    logic x_a;
    logic x_b;
    logic x_c;
    logic x_far;
    logic z_lt_mid;
    logic z_out_far;
    logic c1_en;
    logic c2_en;
    logic w_en;
    logic y_big;
  } srt_flags_t;

  function automatic int wall_n(input int w);
    case (w)
      WALL_TOP: return 14;
      WALL_BOT: return 24;
      WALL_LFT: return 9;
      default:  return 6;
    endcase
  endfunction

  function automatic logic wall_below(input int w);
    return (w == WALL_TOP) || (w == WALL_RGT);
  endfunction

  function automatic int wall_z(input int w, input int i);
    case (w)
      WALL_TOP: return TOP_Z[i];
      WALL_BOT: return BOT_Z[i];
      WALL_LFT: return LFT_Z[i];
      default:  return RGT_Z[i];
    endcase
  endfunction

  function automatic int wall_x(input int w, input int i);
    case (w)
      WALL_TOP: return TOP_X[i];
      WALL_BOT: return BOT_X[i];
      WALL_LFT: return LFT_X[i];
      default:  return RGT_X[i];
    endcase
  endfunction

endpackage

>>> sv/spectrometer_region_test.sv
// ----------------------------------------------------------------------------
// spectrometer_region_test
// Region membership test for one point per cycle.
// ----------------------------------------------------------------------------
// Pulse start_i with a point; busy_o stays low, so a point is taken every
// cycle. The answer appears on inside_res_o with done_o high for one cycle,
// in order. The depth is set by the wall cross products and the wedge
// tangent product, each with a register before and after. The receiver
// cannot stall the block and needs none.
module spectrometer_region_test #(
  parameter int CoordFracBits = srt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [srt_pkg::COORD_W-1:0]  pos_x_i,
  input  logic signed [srt_pkg::COORD_W-1:0]  pos_y_i,
  input  logic signed [srt_pkg::COORD_W-1:0]  pos_z_i,
  output logic                                done_o,
  output logic                                inside_res_o
);
  import srt_pkg::*;

  function automatic logic signed [CMP_W-1:0] sc(input int v);
    return CMP_W'(v) <<< CoordFracBits;
  endfunction

  localparam logic signed [2*CMP_W:0] R1SQ =
    (2*CMP_W+1)'((longint'(C1_R) << CoordFracBits) * (longint'(C1_R) << CoordFracBits));
  localparam logic signed [2*CMP_W:0] R2SQ =
    (2*CMP_W+1)'((longint'(C2_R) << CoordFracBits) * (longint'(C2_R) << CoordFracBits));
  localparam logic signed [WEDGE_W-1:0] WD = WEDGE_W'(longint'(WEDGE_D) << CoordFracBits);

  logic signed [CMP_W-1:0]  xs, ys, zs;
  logic signed [WALL_W-1:0] x10, z10;
  logic [COORD_W:0]         ay_d;
  srt_flags_t               fl_d, fl1_q, fl2_q, fl3_q;
  logic [COORD_W:0]         ay1_q, ay2_q, ay3_q;
  logic v1_q, v2_q, v3_q;
  logic signed [CMP_W-1:0]  a1_q, b1_q, a2_q, b2_q;
  logic signed [WEDGE_W-1:0] cx_q, sz_q, wb_q;
  logic signed [2*CMP_W-1:0] sa1_q, sb1_q, sa2_q, sb2_q;
  logic c1_out_q, c2_in_q;
  logic signed [WIDE_W-1:0] bt_q;
  logic top_hit, bot_hit, lft_hit, rgt_hit;
  logic wedge_out, wall_out, res_d;

  assign busy_o = 1'b0;

  assign xs  = CMP_W'(pos_x_i);
  assign ys  = CMP_W'(pos_y_i);
  assign zs  = CMP_W'(pos_z_i);
  assign x10 = (WALL_W'(pos_x_i) <<< 3) + (WALL_W'(pos_x_i) <<< 1);
  assign z10 = (WALL_W'(pos_z_i) <<< 3) + (WALL_W'(pos_z_i) <<< 1);
  assign ay_d = ys[CMP_W-1] ? (COORD_W+1)'(-ys) : (COORD_W+1)'(ys);

  always_comb begin
    fl_d.z_bad     = (zs > sc(Z_MAX)) || (zs < 0);
    fl_d.x_a       = xs > sc(X_LIM_A);
    fl_d.x_b       = xs > sc(X_LIM_B);
    fl_d.x_c       = xs > sc(X_LIM_C);
    fl_d.x_far     = xs < sc(X_LIM_C);
    fl_d.z_lt_mid  = zs < sc(Z_MIN_MID);
    fl_d.z_out_far = (zs < sc(Z_LO_FAR)) || (zs > sc(Z_HI_FAR));
    fl_d.c1_en     = (zs > sc(C1_Z)) && (xs > sc(C1_X));
    fl_d.c2_en     = (zs > sc(C2_Z)) && (xs > sc(C2_X));
    fl_d.w_en      = (zs > sc(W_Z)) && (xs > sc(W_X));
    fl_d.y_big     = CMP_W'(ay_d) > CMP_W'(Y_LIM << CoordFracBits);
  end

  srt_wall #(.Wall(WALL_TOP), .Frac(CoordFracBits)) u_top (
    .clk_i(clk_i), .x10_i(x10), .z10_i(z10), .hit_o(top_hit));
  srt_wall #(.Wall(WALL_BOT), .Frac(CoordFracBits)) u_bot (
    .clk_i(clk_i), .x10_i(x10), .z10_i(z10), .hit_o(bot_hit));
  srt_wall #(.Wall(WALL_LFT), .Frac(CoordFracBits)) u_lft (
    .clk_i(clk_i), .x10_i(x10), .z10_i(z10), .hit_o(lft_hit));
  srt_wall #(.Wall(WALL_RGT), .Frac(CoordFracBits)) u_rgt (
    .clk_i(clk_i), .x10_i(x10), .z10_i(z10), .hit_o(rgt_hit));

  always_ff @(posedge clk_i) begin
    // stage 1
    fl1_q <= fl_d;
    ay1_q <= ay_d;
    a1_q  <= -xs - sc(C1_AX);
    b1_q  <= zs - sc(C1_BZ);
    a2_q  <= -xs - sc(C2_AX);
    b2_q  <= zs - sc(C2_BZ);
    cx_q  <= WEDGE_W'(pos_x_i) * WEDGE_W'(WEDGE_COS);
    sz_q  <= WEDGE_W'(zs - sc(W_Z0)) * WEDGE_W'(WEDGE_SIN);
    // stage 2
    fl2_q <= fl1_q;
    ay2_q <= ay1_q;
    sa1_q <= a1_q * a1_q;
    sb1_q <= b1_q * b1_q;
    sa2_q <= a2_q * a2_q;
    sb2_q <= b2_q * b2_q;
    wb_q  <= cx_q + sz_q + WD;
    // stage 3
    fl3_q    <= fl2_q;
    ay3_q    <= ay2_q;
    c1_out_q <= ((2*CMP_W+1)'(sa1_q) + (2*CMP_W+1)'(sb1_q)) > R1SQ;
    c2_in_q  <= ((2*CMP_W+1)'(sa2_q) + (2*CMP_W+1)'(sb2_q)) < R2SQ;
    bt_q     <= WIDE_W'(wb_q) * WIDE_W'(WEDGE_TAN);
    // stage 4
    inside_res_o <= res_d;
  end

  assign wedge_out = $signed(WIDE_W'(ay3_q) << WEDGE_SHIFT) > bt_q;

  always_comb begin
    if (fl3_q.x_a) begin
      wall_out = top_hit || bot_hit;
    end else if (fl3_q.x_b) begin
      wall_out = fl3_q.z_lt_mid || lft_hit || rgt_hit;
    end else if (fl3_q.x_c) begin
      wall_out = fl3_q.z_out_far;
    end else begin
      wall_out = 1'b0;
    end
    res_d = !fl3_q.z_bad && !wall_out
         && !(fl3_q.c1_en && c1_out_q)
         && !(fl3_q.c2_en ? c2_in_q : fl3_q.x_far)
         && !(fl3_q.w_en ? wedge_out : fl3_q.y_big);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_o <= v3_q;
    end
  end

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 4))
    else $error("result strobe without a transfer four cycles earlier");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised");

  a_neg_z_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(pos_z_i[COORD_W-1], 4)) |-> !inside_res_o)
    else $error("negative z reported inside");

endmodule

>>> sv/srt_wall.sv
// ----------------------------------------------------------------------------
// srt_wall
// Three-stage wall test: segment select, cross products, sign decision.
// ----------------------------------------------------------------------------
module srt_wall #(
  parameter int Wall = srt_pkg::WALL_TOP,
  parameter int Frac = srt_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic signed [srt_pkg::WALL_W-1:0]  x10_i,
  input  logic signed [srt_pkg::WALL_W-1:0]  z10_i,
  output logic                               hit_o
);
  import srt_pkg::*;

  localparam int   N     = wall_n(Wall);
  localparam int   NS    = N - 1;
  localparam logic Below = wall_below(Wall);

  function automatic logic signed [WALL_W-1:0] scale(input int v);
    return WALL_W'(v) <<< Frac;
  endfunction

  logic [NS-1:0] seg_hit;
  logic signed [WALL_W-1:0] u_d, v_d, dz_d, dx_d;
  logic signed [WALL_W-1:0] u_q, v_q, dz_q, dx_q;
  logic in1_q, in2_q;
  logic signed [PROD_W-1:0] p1_q, p2_q;
  logic signed [PROD_W-1:0] diff;

  for (genvar i = 0; i < NS; i++) begin : g_seg
    localparam logic signed [WALL_W-1:0] ZA = scale(wall_z(Wall, i));
    localparam logic signed [WALL_W-1:0] ZB = scale(wall_z(Wall, i + 1));
    if (i == NS - 1) begin : g_last
      assign seg_hit[i] = (z10_i >= ZA) && (z10_i <= ZB);
    end else begin : g_mid
      assign seg_hit[i] = (z10_i >= ZA) && (z10_i < ZB);
    end
  end

  always_comb begin
    u_d  = '0;
    v_d  = '0;
    dz_d = '0;
    dx_d = '0;
    for (int i = 0; i < NS; i++) begin
      if (seg_hit[i]) begin
        u_d  = u_d  | (x10_i - scale(wall_x(Wall, i)));
        v_d  = v_d  | (z10_i - scale(wall_z(Wall, i)));
        dz_d = dz_d | (scale(wall_z(Wall, i + 1)) - scale(wall_z(Wall, i)));
        dx_d = dx_d | (scale(wall_x(Wall, i + 1)) - scale(wall_x(Wall, i)));
      end
    end
  end

  assign diff = p1_q - p2_q;

  always_ff @(posedge clk_i) begin
    u_q   <= u_d;
    v_q   <= v_d;
    dz_q  <= dz_d;
    dx_q  <= dx_d;
    in1_q <= |seg_hit;
    p1_q  <= u_q * dz_q;
    p2_q  <= dx_q * v_q;
    in2_q <= in1_q;
    hit_o <= in2_q && (Below ? (diff <= 0) : (diff >= 0));
  end

endmodule
